// ===== hdl/pfgs_pkg.sv =====
// shared types, constants and helpers for the particle friction/gravity step block
// no dependencies
package pfgs_pkg;

    localparam int unsigned DivSteps  = 64;
    localparam int unsigned SqrtSteps = 32;

    localparam logic [31:0] MASS_RESET    = 32'd65536;
    localparam logic [23:0] COEF_RESET    = 24'd0;
    localparam logic [23:0] GRAVITY_RESET = 24'd642253;
    localparam logic [63:0] ZERO_BAND     = 64'd85899346;

    typedef enum logic [1:0] {
        CFG_MASS    = 2'd0,
        CFG_COEF    = 2'd1,
        CFG_GRAVITY = 2'd2,
        CFG_NONE    = 2'd3
    } cfg_index_t;

    typedef enum logic [1:0] {
        FUNC_TICK  = 2'd0,
        FUNC_FORCE = 2'd1,
        FUNC_LOADP = 2'd2,
        FUNC_LOADV = 2'd3
    } func_t;

    typedef enum logic [4:0] {
        ST_IDLE, ST_SQ_MUL, ST_SQ_ACC, ST_SQRT_GO, ST_SQRT_WAIT,
        ST_CG_MUL, ST_CG_HI, ST_DH_MUL, ST_DH_ACC, ST_DL_MUL, ST_DL_ACC,
        ST_FR_MUL, ST_FR_DIV, ST_FR_WAIT, ST_ZB_MUL, ST_ZB_CHK,
        ST_GZ_MUL, ST_GZ_SUB, ST_PM_MUL, ST_PM_ADD, ST_CLAMP,
        ST_F_MUL, ST_F_DIV, ST_F_WAIT, ST_OUT
    } state_t;

    // magnitude of a signed word, most negative value included
    function automatic logic [31:0] abs32(input logic [31:0] v);
        abs32 = v[31] ? (~v + 32'd1) : v;
    endfunction

    // a + q or a - q, clamped to the signed 32-bit range
    function automatic logic [31:0] sat_add(input logic [31:0] a, input logic [63:0] q,
                                            input logic neg);
        logic signed [66:0] s;
        logic signed [66:0] qs;
        qs = $signed({3'b000, q});
        s  = $signed({{35{a[31]}}, a}) + (neg ? -qs : qs);
        if (s > $signed(67'h0_7FFF_FFFF)) begin
            sat_add = 32'h7FFF_FFFF;
        end else if (s < -$signed(67'h0_8000_0000)) begin
            sat_add = 32'h8000_0000;
        end else begin
            sat_add = s[31:0];
        end
    endfunction

endpackage

// ===== hdl/pfgs_mul.sv =====
// shared 32x32 unsigned multiplier with registered product
// uses pfgs_pkg nothing; standalone
module pfgs_mul (
    input  logic        aclk,
    input  logic [31:0] op_a,
    input  logic [31:0] op_b,
    output logic [63:0] prod
);
    logic [63:0] prod_reg;

    always_ff @(posedge aclk) begin
        prod_reg <= op_a * op_b;
    end

    assign prod = prod_reg;
endmodule

// ===== hdl/pfgs_div.sv =====
// restoring divider, 64-bit dividend by 32-bit divisor, one quotient bit a cycle
// depends on pfgs_pkg
module pfgs_div (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        start,
    input  logic [63:0] dividend,
    input  logic [31:0] divisor,
    output logic        done,
    output logic [63:0] quotient
);
    import pfgs_pkg::*;

    logic [31:0] rem_reg, rem_next;
    logic [63:0] quo_reg, quo_next;
    logic [31:0] dv_reg, dv_next;
    logic [6:0]  cnt_reg, cnt_next;
    logic        done_reg, done_next;
    logic [32:0] trial;

    always_comb begin
        rem_next  = rem_reg;
        quo_next  = quo_reg;
        dv_next   = dv_reg;
        cnt_next  = cnt_reg;
        done_next = 1'b0;
        trial     = {rem_reg, quo_reg[63]};
        if (start) begin
            rem_next = '0;
            quo_next = dividend;
            dv_next  = divisor;
            cnt_next = 7'(DivSteps);
        end else if (cnt_reg != '0) begin
            if (trial >= {1'b0, dv_reg}) begin
                rem_next = 32'(trial - {1'b0, dv_reg});
                quo_next = {quo_reg[62:0], 1'b1};
            end else begin
                rem_next = trial[31:0];
                quo_next = {quo_reg[62:0], 1'b0};
            end
            cnt_next  = cnt_reg - 7'd1;
            done_next = (cnt_reg == 7'd1);
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cnt_reg  <= '0;
            done_reg <= 1'b0;
        end else begin
            cnt_reg  <= cnt_next;
            done_reg <= done_next;
        end
        rem_reg <= rem_next;
        quo_reg <= quo_next;
        dv_reg  <= dv_next;
    end

    assign done     = done_reg;
    assign quotient = quo_reg;
endmodule

// ===== hdl/pfgs_sqrt.sv =====
// integer square root of a 64-bit value, two radicand bits a cycle
// depends on pfgs_pkg
module pfgs_sqrt (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        start,
    input  logic [63:0] radicand,
    output logic        done,
    output logic [31:0] root
);
    import pfgs_pkg::*;

    logic [63:0] x_reg, x_next;
    logic [32:0] rem_reg, rem_next;
    logic [31:0] root_reg, root_next;
    logic [5:0]  cnt_reg, cnt_next;
    logic        done_reg, done_next;
    logic [34:0] r;
    logic [34:0] trial;

    always_comb begin
        x_next    = x_reg;
        rem_next  = rem_reg;
        root_next = root_reg;
        cnt_next  = cnt_reg;
        done_next = 1'b0;
        r         = {rem_reg, x_reg[63:62]};
        trial     = {1'b0, root_reg, 2'b01};
        if (start) begin
            x_next    = radicand;
            rem_next  = '0;
            root_next = '0;
            cnt_next  = 6'(SqrtSteps);
        end else if (cnt_reg != '0) begin
            if (r >= trial) begin
                rem_next  = 33'(r - trial);
                root_next = {root_reg[30:0], 1'b1};
            end else begin
                rem_next  = r[32:0];
                root_next = {root_reg[30:0], 1'b0};
            end
            x_next    = {x_reg[61:0], 2'b00};
            cnt_next  = cnt_reg - 6'd1;
            done_next = (cnt_reg == 6'd1);
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cnt_reg  <= '0;
            done_reg <= 1'b0;
        end else begin
            cnt_reg  <= cnt_next;
            done_reg <= done_next;
        end
        x_reg    <= x_next;
        rem_reg  <= rem_next;
        root_reg <= root_next;
    end

    assign done = done_reg;
    assign root = root_reg;
endmodule

// ===== hdl/particle_friction_gravity_step.sv =====
// one-body euler step in signed q16.16: tick, apply force, load position or velocity
// work: a tick of a moving body runs a square root and up to two divides (one per moving x/y axis),
// a force runs three divides, a load goes straight to the result word
// throughput: one item at a time; the next word is taken after the result is taken
// reset: synchronous active-low aresetn clears state, position and velocity, loads defaults
// depends on pfgs_pkg, pfgs_mul, pfgs_div, pfgs_sqrt
module particle_friction_gravity_step (
    input  logic                     aclk,
    input  logic                     aresetn,
    input  logic                     s_tvalid,
    output logic                     s_tready,
    input  logic [111:0]             s_tdata,   // dt, vec_x, vec_y, vec_z
    input  pfgs_pkg::func_t          s_tuser,   // func
    output logic                     m_tvalid,
    input  logic                     m_tready,
    output logic [191:0]             m_tdata,   // pos_x, pos_y, pos_z, vel_x, vel_y, vel_z
    input  logic                     cfg_wr_en,
    input  pfgs_pkg::cfg_index_t     cfg_index,
    input  logic [31:0]              cfg_wdata
);
    import pfgs_pkg::*;

    state_t      state_reg, state_next;
    logic [1:0]  idx_reg, idx_next;
    logic [15:0] dt_reg, dt_next;
    logic [31:0] vec_reg [3];
    logic [31:0] vec_next [3];
    logic [31:0] pos_reg [3];
    logic [31:0] pos_next [3];
    logic [31:0] vel_reg [3];
    logic [31:0] vel_next [3];
    logic [63:0] acc_reg, acc_next;
    logic [47:0] t_reg, t_next;
    logic [31:0] speed_reg, speed_next;
    logic [31:0] d_reg, d_next;
    logic [31:0] n_reg, n_next;
    logic [31:0] mass_reg, coef_reg, grav_reg;

    logic [31:0] mul_a, mul_b;
    logic [63:0] mul_p;
    logic        div_start, div_done;
    logic [63:0] div_dividend, div_q;
    logic [31:0] div_divisor;
    logic        sqrt_start, sqrt_done;
    logic [31:0] sqrt_root;
    logic [63:0] sum64;
    logic [63:0] step_mag;

    pfgs_mul u_mul (.aclk(aclk), .op_a(mul_a), .op_b(mul_b), .prod(mul_p));

    pfgs_div u_div (
        .aclk(aclk), .aresetn(aresetn), .start(div_start), .dividend(div_dividend),
        .divisor(div_divisor), .done(div_done), .quotient(div_q)
    );

    pfgs_sqrt u_sqrt (
        .aclk(aclk), .aresetn(aresetn), .start(sqrt_start), .radicand(acc_reg),
        .done(sqrt_done), .root(sqrt_root)
    );

    always_comb begin
        state_next   = state_reg;
        idx_next     = idx_reg;
        dt_next      = dt_reg;
        vec_next     = vec_reg;
        pos_next     = pos_reg;
        vel_next     = vel_reg;
        acc_next     = acc_reg;
        t_next       = t_reg;
        speed_next   = speed_reg;
        d_next       = d_reg;
        n_next       = n_reg;
        mul_a        = '0;
        mul_b        = '0;
        div_start    = 1'b0;
        div_dividend = mul_p;
        div_divisor  = speed_reg;
        sqrt_start   = 1'b0;
        sum64        = acc_reg + mul_p;
        step_mag     = '0;
        case (state_reg)
            ST_IDLE: begin
                if (s_tvalid) begin
                    dt_next     = s_tdata[15:0];
                    vec_next[0] = s_tdata[47:16];
                    vec_next[1] = s_tdata[79:48];
                    vec_next[2] = s_tdata[111:80];
                    idx_next    = '0;
                    acc_next    = '0;
                    case (s_tuser)
                        FUNC_TICK:  state_next = ST_SQ_MUL;
                        FUNC_FORCE: state_next = ST_F_MUL;
                        FUNC_LOADP: begin
                            pos_next   = vec_next;
                            state_next = ST_OUT;
                        end
                        default: begin
                            vel_next   = vec_next;
                            state_next = ST_OUT;
                        end
                    endcase
                end
            end
            ST_SQ_MUL: begin
                mul_a      = abs32(vel_reg[idx_reg]);
                mul_b      = abs32(vel_reg[idx_reg]);
                state_next = ST_SQ_ACC;
            end
            ST_SQ_ACC: begin
                acc_next = sum64;
                if (idx_reg == 2'd2) begin
                    idx_next   = '0;
                    // at rest: no friction and no gravity
                    state_next = (sum64 == '0) ? ST_PM_MUL : ST_SQRT_GO;
                end else begin
                    idx_next   = idx_reg + 2'd1;
                    state_next = ST_SQ_MUL;
                end
            end
            ST_SQRT_GO: begin
                sqrt_start = 1'b1;
                state_next = ST_SQRT_WAIT;
            end
            ST_SQRT_WAIT: begin
                if (sqrt_done) begin
                    speed_next = sqrt_root;
                    state_next = ST_CG_MUL;
                end
            end
            ST_CG_MUL: begin
                mul_a      = {8'd0, coef_reg[23:0]};
                mul_b      = {8'd0, grav_reg[23:0]};
                state_next = ST_CG_HI;
            end
            ST_CG_HI: begin
                t_next     = mul_p[47:0];
                state_next = ST_DH_MUL;
            end
            ST_DH_MUL: begin
                mul_a      = t_reg[47:16];
                mul_b      = {16'd0, dt_reg};
                state_next = ST_DH_ACC;
            end
            ST_DH_ACC: begin
                acc_next   = {mul_p[47:0], 16'd0};
                state_next = ST_DL_MUL;
            end
            ST_DL_MUL: begin
                mul_a      = {16'd0, t_reg[15:0]};
                mul_b      = {16'd0, dt_reg};
                state_next = ST_DL_ACC;
            end
            ST_DL_ACC: begin
                d_next     = sum64[63:32];
                idx_next   = '0;
                state_next = ST_FR_MUL;
            end
            ST_FR_MUL: begin
                mul_a = abs32(vel_reg[idx_reg]);
                mul_b = d_reg;
                if (vel_reg[idx_reg] == '0) begin
                    n_next     = '0;
                    state_next = ST_ZB_MUL;
                end else begin
                    state_next = ST_FR_DIV;
                end
            end
            ST_FR_DIV: begin
                div_start  = 1'b1;
                state_next = ST_FR_WAIT;
            end
            ST_FR_WAIT: begin
                if (div_done) begin
                    // friction opposes the sign of the velocity
                    n_next     = sat_add(vel_reg[idx_reg], div_q, ~vel_reg[idx_reg][31]);
                    state_next = ST_ZB_MUL;
                end
            end
            ST_ZB_MUL: begin
                mul_a      = abs32(n_reg);
                mul_b      = abs32(vel_reg[idx_reg]);
                state_next = ST_ZB_CHK;
            end
            ST_ZB_CHK: begin
                if (n_reg == '0 || n_reg[31] != vel_reg[idx_reg][31] || mul_p < ZERO_BAND) begin
                    vel_next[idx_reg] = '0;
                end else begin
                    vel_next[idx_reg] = n_reg;
                end
                if (idx_reg == 2'd1) begin
                    state_next = ST_GZ_MUL;
                end else begin
                    idx_next   = idx_reg + 2'd1;
                    state_next = ST_FR_MUL;
                end
            end
            ST_GZ_MUL: begin
                mul_a      = {8'd0, grav_reg[23:0]};
                mul_b      = {16'd0, dt_reg};
                state_next = ST_GZ_SUB;
            end
            ST_GZ_SUB: begin
                vel_next[2] = sat_add(vel_reg[2], {40'd0, mul_p[39:16]}, 1'b1);
                idx_next    = '0;
                state_next  = ST_PM_MUL;
            end
            ST_PM_MUL: begin
                mul_a      = abs32(vel_reg[idx_reg]);
                mul_b      = {16'd0, dt_reg};
                state_next = ST_PM_ADD;
            end
            ST_PM_ADD: begin
                // floor of a negative product rounds away from zero in magnitude
                step_mag = vel_reg[idx_reg][31] ? ((mul_p + 64'd65535) >> 16) : (mul_p >> 16);
                pos_next[idx_reg] = sat_add(pos_reg[idx_reg], step_mag, vel_reg[idx_reg][31]);
                if (idx_reg == 2'd2) begin
                    state_next = ST_CLAMP;
                end else begin
                    idx_next   = idx_reg + 2'd1;
                    state_next = ST_PM_MUL;
                end
            end
            ST_CLAMP: begin
                if (pos_reg[2][31] || pos_reg[2] == '0) begin
                    pos_next[2] = '0;
                    vel_next[2] = '0;
                end
                state_next = ST_OUT;
            end
            ST_F_MUL: begin
                mul_a      = abs32(vec_reg[idx_reg]);
                mul_b      = {16'd0, dt_reg};
                state_next = ST_F_DIV;
            end
            ST_F_DIV: begin
                div_start   = 1'b1;
                div_divisor = (mass_reg == '0) ? 32'd1 : mass_reg;
                state_next  = ST_F_WAIT;
            end
            ST_F_WAIT: begin
                if (div_done) begin
                    vel_next[idx_reg] = sat_add(vel_reg[idx_reg], div_q, vec_reg[idx_reg][31]);
                    if (idx_reg == 2'd2) begin
                        state_next = ST_OUT;
                    end else begin
                        idx_next   = idx_reg + 2'd1;
                        state_next = ST_F_MUL;
                    end
                end
            end
            ST_OUT: begin
                if (m_tready) begin
                    state_next = ST_IDLE;
                end
            end
            default: state_next = ST_IDLE;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ST_IDLE;
            idx_reg   <= '0;
            pos_reg   <= '{default: '0};
            vel_reg   <= '{default: '0};
            mass_reg  <= MASS_RESET;
            coef_reg  <= {8'd0, COEF_RESET};
            grav_reg  <= {8'd0, GRAVITY_RESET};
        end else begin
            state_reg <= state_next;
            idx_reg   <= idx_next;
            pos_reg   <= pos_next;
            vel_reg   <= vel_next;
            if (cfg_wr_en) begin
                case (cfg_index)
                    CFG_MASS:    mass_reg <= cfg_wdata;
                    CFG_COEF:    coef_reg <= {8'd0, cfg_wdata[23:0]};
                    CFG_GRAVITY: grav_reg <= {8'd0, cfg_wdata[23:0]};
                    default: ;
                endcase
            end
        end
        dt_reg    <= dt_next;
        vec_reg   <= vec_next;
        acc_reg   <= acc_next;
        t_reg     <= t_next;
        speed_reg <= speed_next;
        d_reg     <= d_next;
        n_reg     <= n_next;
    end

    assign s_tready = (state_reg == ST_IDLE);
    assign m_tvalid = (state_reg == ST_OUT);
    assign m_tdata  = {vel_reg[2], vel_reg[1], vel_reg[0], pos_reg[2], pos_reg[1], pos_reg[0]};

    a_one_side: assert property (@(posedge aclk) disable iff (!aresetn)
        !(s_tready && m_tvalid))
        else $error("input and result sides open together");

    a_busy_after_accept: assert property (@(posedge aclk) disable iff (!aresetn)
        (s_tvalid && s_tready && s_tuser != FUNC_LOADP && s_tuser != FUNC_LOADV)
        |=> !s_tready && !m_tvalid)
        else $error("computing item not held busy");

    a_idle_after_out: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_tvalid && m_tready) |=> (s_tready && !m_tvalid))
        else $error("no return to idle after result word");

    a_ground_clamp: assert property (@(posedge aclk) disable iff (!aresetn)
        ($past(state_reg) == ST_CLAMP) |-> !pos_reg[2][31])
        else $error("height below ground after tick");
endmodule

// ===== tb/tb_top.sv =====
`timescale 1ns / 100ps
// self-checking testbench for particle_friction_gravity_step: directed and random words
// with random stalls on both sides, checked against a behavioral predictor; needs pfgs_pkg
module tb_top;
    import pfgs_pkg::*;

    typedef struct packed {
        func_t       func;
        logic [15:0] dt;
        logic [31:0] vx;
        logic [31:0] vy;
        logic [31:0] vz;
    } step_word_t;

    typedef struct packed {
        logic [31:0] px, py, pz, vx, vy, vz;
    } body_state_t;

    logic          aclk = 1'b0;
    logic          aresetn = 1'b0;
    logic          s_tvalid = 1'b0;
    logic          s_tready;
    logic [111:0]  s_tdata = '0;
    func_t         s_tuser = FUNC_TICK;
    logic          m_tvalid;
    logic          m_tready = 1'b0;
    logic [191:0]  m_tdata;
    logic          cfg_wr_en = 1'b0;
    cfg_index_t    cfg_index = CFG_MASS;
    logic [31:0]   cfg_wdata = '0;

    particle_friction_gravity_step u_top (.*);

    always begin
        #5 aclk = 1'b1;
        #5 aclk = 1'b0;
    end

    // predictor state and registers
    longint      pos_m[3];
    longint      vel_m[3];
    logic [31:0] mass_m;
    logic [23:0] coef_m;
    logic [23:0] grav_m;

    step_word_t  pending_q[$];
    body_state_t expected_q[$];
    int          errors = 0;
    longint      cycles = 0;
    bit          quiet = 1'b0;
    int          src_gap = 0;
    int          snk_gap = 0;

    function automatic longint clamp32(longint v);
        if (v > 64'sd2147483647) return 64'sd2147483647;
        if (v < -64'sd2147483648) return -64'sd2147483648;
        return v;
    endfunction

    function automatic longint sx32(logic [31:0] v);
        return longint'($signed(v));
    endfunction

    function automatic logic [63:0] magn(longint v);
        return v < 0 ? 64'(-v) : 64'(v);
    endfunction

    function automatic logic [63:0] root64(logic [63:0] x);
        logic [63:0] r, bitv;
        r = 0;
        bitv = 64'd1 << 62;
        while (bitv > x) bitv >>= 2;
        while (bitv != 0) begin
            if (x >= r + bitv) begin
                x -= r + bitv;
                r = (r >> 1) + bitv;
            end else begin
                r >>= 1;
            end
            bitv >>= 2;
        end
        return r;
    endfunction

    task automatic advance_body(input step_word_t w);
        logic [63:0]  s, spd, dec, m, q, p;
        logic [127:0] prod;
        longint v, n, dp;
        if (w.func == FUNC_TICK) begin
            s = 0;
            for (int i = 0; i < 3; i++) s += magn(vel_m[i]) * magn(vel_m[i]);
            if (s != 0) begin
                spd = root64(s);
                prod = 128'(coef_m) * 128'(grav_m) * 128'(w.dt);
                dec = 64'(prod >> 32);
                for (int i = 0; i < 2; i++) begin
                    v = vel_m[i];
                    n = 0;
                    if (v != 0) begin
                        q = 64'((128'(magn(v)) * 128'(dec)) / 128'(spd));
                        n = clamp32(v > 0 ? v - longint'(q) : v + longint'(q));
                    end
                    if (n * v < 64'sd85899346) n = 0;
                    vel_m[i] = n;
                end
                vel_m[2] = clamp32(vel_m[2] - longint'((64'(grav_m) * w.dt) >> 16));
            end
            for (int i = 0; i < 3; i++) begin
                p = magn(vel_m[i]) * w.dt;
                dp = vel_m[i] < 0 ? -longint'((p + 65535) >> 16) : longint'(p >> 16);
                pos_m[i] = clamp32(pos_m[i] + dp);
            end
            if (pos_m[2] <= 0) begin
                pos_m[2] = 0;
                vel_m[2] = 0;
            end
        end else if (w.func == FUNC_FORCE) begin
            m = mass_m == 0 ? 64'd1 : 64'(mass_m);
            for (int i = 0; i < 3; i++) begin
                v = sx32(i == 0 ? w.vx : i == 1 ? w.vy : w.vz);
                q = (magn(v) * w.dt) / m;
                vel_m[i] = clamp32(vel_m[i] + (v < 0 ? -longint'(q) : longint'(q)));
            end
        end else if (w.func == FUNC_LOADP) begin
            pos_m[0] = sx32(w.vx); pos_m[1] = sx32(w.vy); pos_m[2] = sx32(w.vz);
        end else begin
            vel_m[0] = sx32(w.vx); vel_m[1] = sx32(w.vy); vel_m[2] = sx32(w.vz);
        end
    endtask

    // driver
    always @(posedge aclk) begin
        step_word_t w;
        bit take;
        cycles <= cycles + 1;
        if (aresetn) begin
            take = 1'b0;
            if (s_tvalid && s_tready) begin
                w.func = s_tuser;
                w.dt   = s_tdata[15:0];
                w.vx   = s_tdata[47:16];
                w.vy   = s_tdata[79:48];
                w.vz   = s_tdata[111:80];
                advance_body(w);
                expected_q.push_back({32'(pos_m[0]), 32'(pos_m[1]), 32'(pos_m[2]),
                                      32'(vel_m[0]), 32'(vel_m[1]), 32'(vel_m[2])});
                void'(pending_q.pop_front());
                take = 1'b1;
            end
            if (s_tvalid && !take) begin
                // hold the word
            end else if (src_gap > 0) begin
                src_gap <= src_gap - 1;
                s_tvalid <= 1'b0;
            end else if (pending_q.size() > 0 && !quiet && $urandom_range(0, 5) == 0
                         && pending_q.size() > 60) begin
                src_gap <= $urandom_range(0, 8);
                s_tvalid <= 1'b0;
            end else if (pending_q.size() > 0) begin
                s_tvalid <= 1'b1;
                s_tuser <= pending_q[0].func;
                s_tdata <= {pending_q[0].vz, pending_q[0].vy, pending_q[0].vx,
                            pending_q[0].dt};
            end else begin
                s_tvalid <= 1'b0;
            end
        end
    end

    // monitor
    always @(posedge aclk) begin
        body_state_t got, want;
        if (aresetn) begin
            if (m_tvalid && m_tready) begin
                got = {m_tdata[31:0], m_tdata[63:32], m_tdata[95:64],
                       m_tdata[127:96], m_tdata[159:128], m_tdata[191:160]};
                if (expected_q.size() == 0) begin
                    $display("%0t: unexpected result word %h", $realtime, m_tdata);
                    errors <= errors + 1;
                end else begin
                    want = expected_q.pop_front();
                    if (got != want) begin
                        $display("%0t: mismatch expected p=%h %h %h v=%h %h %h", $realtime,
                                 want.px, want.py, want.pz, want.vx, want.vy, want.vz);
                        $display("%0t:            actual p=%h %h %h v=%h %h %h", $realtime,
                                 got.px, got.py, got.pz, got.vx, got.vy, got.vz);
                        errors <= errors + 1;
                    end
                end
            end
            if (snk_gap > 0) begin
                snk_gap <= snk_gap - 1;
                m_tready <= 1'b0;
            end else if (pending_q.size() > 60 && $urandom_range(0, 4) == 0) begin
                snk_gap <= $urandom_range(0, 8);
                m_tready <= 1'b0;
            end else begin
                m_tready <= 1'b1;
            end
        end
    end

    always @(posedge aclk) begin
        if (cycles > 64'd3000000) begin
            $display("== FAIL ==");
            $finish;
        end
    end

    function automatic logic [31:0] rnd_q(int shift);
        logic [31:0] r;
        r = $urandom();
        return shift >= 32 ? r : 32'($signed(r) >>> shift);
    endfunction

    task automatic add_word(func_t f, logic [15:0] dt, logic [31:0] x, logic [31:0] y,
                            logic [31:0] z);
        step_word_t w;
        w.func = f; w.dt = dt; w.vx = x; w.vy = y; w.vz = z;
        pending_q.push_back(w);
    endtask

    task automatic drain();
        while (pending_q.size() > 0 || s_tvalid || expected_q.size() > 0) @(posedge aclk);
        repeat (20) @(posedge aclk);
    endtask

    task automatic write_reg(cfg_index_t idx, logic [31:0] val);
        cfg_wr_en <= 1'b1;
        cfg_index <= idx;
        cfg_wdata <= val;
        @(posedge aclk);
        cfg_wr_en <= 1'b0;
        case (idx)
            CFG_MASS:    mass_m = val;
            CFG_COEF:    coef_m = val[23:0];
            CFG_GRAVITY: grav_m = val[23:0];
            default: ;
        endcase
    endtask

    // one random word, a tick half of the time, with a plausible state
    task automatic add_random();
        int k;
        int sh;
        k = $urandom_range(0, 9);
        sh = $urandom_range(0, 3) == 0 ? 0 : $urandom_range(8, 16);
        if (k < 5) add_word(FUNC_TICK, 16'($urandom()), 0, 0, 0);
        else if (k < 7)
            add_word(FUNC_FORCE, 16'($urandom()), rnd_q(sh), rnd_q(sh), rnd_q(sh));
        else if (k < 8)
            add_word(FUNC_LOADP, 16'($urandom()), rnd_q(sh), rnd_q(sh), rnd_q(sh) & 32'h7fffffff);
        else add_word(FUNC_LOADV, 16'($urandom()), rnd_q(sh), rnd_q(sh), rnd_q(sh));
    endtask

    initial begin
        logic [31:0] masses[4];
        logic [23:0] coefs[4];
        logic [23:0] gravs[4];
        mass_m = MASS_RESET;
        coef_m = COEF_RESET;
        grav_m = GRAVITY_RESET;
        for (int i = 0; i < 3; i++) begin
            pos_m[i] = 0;
            vel_m[i] = 0;
        end
        repeat (10) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        // directed: defaults, tick at rest, extremes, saturation, zero band, ground clamp
        add_word(FUNC_TICK, 16'hffff, 0, 0, 0);
        add_word(FUNC_LOADP, 0, 32'h7fffffff, 32'h80000000, 32'h00010000);
        add_word(FUNC_LOADV, 0, 32'h7fffffff, 32'h80000000, 32'h80000000);
        add_word(FUNC_TICK, 16'hffff, 0, 0, 0);
        add_word(FUNC_FORCE, 16'hffff, 32'h7fffffff, 32'h80000000, 32'h7fffffff);
        add_word(FUNC_FORCE, 16'h0000, 32'hffffffff, 32'hffffffff, 32'hffffffff);
        add_word(FUNC_LOADP, 16'hffff, 32'h00100000, 32'hfff00000, 32'h00200000);
        add_word(FUNC_LOADV, 0, 32'h00000100, 32'hffffff00, 32'h00030000);
        add_word(FUNC_TICK, 16'h1000, 0, 0, 0);
        add_word(FUNC_LOADV, 0, 32'h00020000, 32'hfffe0000, 32'hfff00000);
        add_word(FUNC_TICK, 16'h8000, 0, 0, 0);
        add_word(FUNC_TICK, 16'h0001, 0, 0, 0);
        drain();

        write_reg(CFG_COEF, 32'h00008000);
        write_reg(CFG_MASS, 32'h0);
        write_reg(CFG_NONE, 32'hffffffff);
        add_word(FUNC_LOADP, 0, 32'h00050000, 32'h00050000, 32'h00500000);
        add_word(FUNC_LOADV, 0, 32'h00030000, 32'hfffd0000, 32'h00010000);
        add_word(FUNC_TICK, 16'h4000, 0, 0, 0);
        add_word(FUNC_TICK, 16'hffff, 0, 0, 0);
        add_word(FUNC_FORCE, 16'h0001, 32'h00000001, 32'hffffffff, 32'h00000003);
        add_word(FUNC_LOADV, 0, 32'h00000050, 32'h00000000, 32'h00000000);
        add_word(FUNC_TICK, 16'h0100, 0, 0, 0);
        add_word(FUNC_LOADV, 0, 32'h7fffffff, 32'h7fffffff, 32'h7fffffff);
        add_word(FUNC_TICK, 16'hffff, 0, 0, 0);
        drain();

        masses = '{32'h00010000, 32'hffffffff, 32'h00000001, 32'h00004000};
        coefs  = '{24'hffffff, 24'h0, 24'h004000, 24'h010000};
        gravs  = '{24'hffffff, 24'h0, 24'h09cccd, 24'h001000};
        for (int ph = 0; ph < 6; ph++) begin
            write_reg(CFG_MASS, ph < 4 ? masses[ph] : $urandom());
            write_reg(CFG_COEF, ph < 4 ? coefs[ph] : 32'($urandom_range(0, 24'hffffff)));
            write_reg(CFG_GRAVITY, ph < 4 ? gravs[ph] : 32'($urandom_range(0, 24'hffffff)));
            if (ph == 5) quiet = 1'b1;
            for (int n = 0; n < 190; n++) add_random();
            drain();
        end

        if (errors == 0) begin
            $display("== PASS ==");
        end else begin
            $display("== FAIL ==");
        end
        $finish;
    end

endmodule
